>>> rtl/wse_pkg.sv
`default_nettype none
package wse_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int WIN_W      = 7;
    localparam int VALUE_W    = 32;
    localparam int TIME_W     = 64;

    // one million = 15625 * 2**6
    localparam int            MUL_K_W  = 14;
    localparam logic [13:0]   MUL_K    = 14'd15625;
    localparam int            MUL_SH   = 6;
    localparam int            PROD_W   = VALUE_W + MUL_K_W;
    localparam int            DVD_W    = PROD_W + MUL_SH;
    localparam int            MCNT_W   = $clog2(MUL_K_W);
    localparam int            DCNT_W   = $clog2(DVD_W);

    localparam logic [VALUE_W-1:0] SLOPE_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] SLOPE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [VALUE_W-1:0] slope;
    } wse_div_status_t;

    function automatic logic [FILL_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [FILL_W-1:0] r;
        if (w == '0)
        begin
            r = FILL_W'(1);
        end
        else if (FILL_W'(w) > FILL_W'(MAX_WINDOW))
        begin
            r = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            r = FILL_W'(w);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/wse_ifs.sv
`default_nettype none
interface wse_sample_if;
    import wse_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic        [TIME_W-1:0]  sample_time_us;
    modport source (output valid, output sample_value, output sample_time_us, input ready);
    modport sink (input valid, input sample_value, input sample_time_us, output ready);
endinterface

interface wse_result_if;
    import wse_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] slope;
    logic                      slope_saturated;
    logic        [TIME_W-1:0]  result_time_us;
    modport source (output valid, output slope, output slope_saturated,
                    output result_time_us, input ready);
    modport sink (input valid, input slope, input slope_saturated,
                  input result_time_us, output ready);
endinterface

interface wse_cfg_if;
    import wse_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface
`default_nettype wire

>>> rtl/windowed_slope_estimator_top.sv
// flow: a sample request is taken and the ring is read; when a division is needed,
// a shift-add multiply and a restoring divide follow before the result is ready
// samples: one at a time, next request taken once the result is handed
// to the output register, which waits while it holds a result not yet taken
// reset: asynchronous active low; fill count, write pointer cleared, window 2,
// ring memories not cleared, no clearing pass
`default_nettype none
module windowed_slope_estimator_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    wse_sample_if.sink   sample,
    wse_result_if.source result,
    wse_cfg_if.sink      cfg
);
    import wse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [VALUE_W-1:0]  new_val_reg;
    logic [TIME_W-1:0]   new_time_reg;
    logic [VALUE_W-1:0]  res_slope_reg, res_slope_next;
    logic                res_sat_reg, res_sat_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_slope_reg;
    logic                out_sat_reg;
    logic [TIME_W-1:0]   out_time_reg;

    logic                accept;
    logic                cfg_write;
    logic                load_out;
    logic [FILL_W-1:0]   win_eff;
    logic [FILL_W-1:0]   cfg_eff;
    logic [FILL_W-1:0]   fill_acc;
    logic [ADDR_W-1:0]   back;
    logic [ADDR_W-1:0]   old_addr;
    logic [VALUE_W-1:0]  old_val;
    logic [TIME_W-1:0]   old_time;
    logic [TIME_W:0]     dt_full;
    logic [VALUE_W:0]    diff;
    logic [VALUE_W:0]    diff_abs;
    logic                later;
    logic                div_start;
    wse_div_status_t     div_st;

    assign accept    = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    // window writes only between samples, a sample request goes first
    assign cfg.ready = (state_reg == S_IDLE) && !sample.valid;
    assign cfg_write = cfg.valid && cfg.ready;
    assign win_eff   = eff_window(window_reg);
    assign cfg_eff   = eff_window(cfg.window_size);
    assign fill_acc  = (fill_reg < win_eff) ? fill_reg + FILL_W'(1) : win_eff;
    assign back      = ADDR_W'(fill_acc - FILL_W'(1));
    assign old_addr  = (wp_reg >= back) ? wp_reg - back
                                        : ADDR_W'(FILL_W'(wp_reg) + FILL_W'(MAX_WINDOW)
                                                  - FILL_W'(back));

    wse_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_WINDOW)) u_val_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample.sample_value),
        .raddr (old_addr),
        .rdata (old_val)
    );

    wse_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WINDOW)) u_time_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample.sample_time_us),
        .raddr (old_addr),
        .rdata (old_time)
    );

    assign dt_full  = {1'b0, new_time_reg} - {1'b0, old_time};
    assign later    = !dt_full[TIME_W] && (|dt_full[TIME_W-1:0]);
    assign diff     = {new_val_reg[VALUE_W-1], new_val_reg} - {old_val[VALUE_W-1], old_val};
    assign diff_abs = diff[VALUE_W] ? '0 - diff : diff;
    assign div_start = (state_reg == S_READ) && (fill_reg >= FILL_W'(2)) && later;

    wse_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .mag    (diff_abs[VALUE_W-1:0]),
        .neg    (diff[VALUE_W]),
        .dt     (dt_full[TIME_W-1:0]),
        .status (div_st)
    );

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        wp_next     = wp_reg;
        if (accept)
        begin
            fill_next = fill_acc;
            wp_next   = (wp_reg == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + ADDR_W'(1);
        end
        else if (cfg_write)
        begin
            window_next = cfg.window_size;
            if (fill_reg > cfg_eff)
            begin
                fill_next = cfg_eff;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_slope_next = res_slope_reg;
        res_sat_next   = res_sat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    res_slope_next = '0;
                    res_sat_next   = 1'b0;
                    state_next     = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    res_slope_next = div_st.slope;
                    res_sat_next   = div_st.sat;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WIN_W'(2);
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_val_reg  <= sample.sample_value;
            new_time_reg <= sample.sample_time_us;
        end
        res_slope_reg <= res_slope_next;
        res_sat_reg   <= res_sat_next;
        if (load_out)
        begin
            out_slope_reg <= res_slope_reg;
            out_sat_reg   <= res_sat_reg;
            out_time_reg  <= new_time_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.slope           = out_slope_reg;
    assign result.slope_saturated = out_sat_reg;
    assign result.result_time_us  = out_time_reg;

    // ring never holds more than the current window
    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count above window");

    // a clamped slope sits at one of the range limits
    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.slope_saturated) |->
            (result.slope == SLOPE_MAX || result.slope == SLOPE_MIN))
        else $error("saturated slope not at a limit");

    // divider finishes only while the control waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // a division is started only with two or more samples held
    a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV) && ($past(fill_reg) >= FILL_W'(2)))
        else $error("division started without two samples");

endmodule
`default_nettype wire

>>> rtl/wse_ram.sv
`default_nettype none
module wse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/wse_muldiv.sv
`default_nettype none
module wse_muldiv (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [wse_pkg::VALUE_W-1:0]    mag,
    input  wire logic                           neg,
    input  wire logic [wse_pkg::TIME_W-1:0]     dt,
    output wse_pkg::wse_div_status_t            status
);
    import wse_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_DIV  = 4'b0100,
        M_DONE = 4'b1000
    } md_state_t;

    md_state_t           state_reg, state_next;
    logic [MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [MUL_K_W-1:0]  k_reg, k_next;
    logic [PROD_W-1:0]   mcand_reg, mcand_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [TIME_W-1:0]   dt_reg, dt_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W:0]    q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic                neg_reg, neg_next;
    logic [PROD_W-1:0]   acc_sum;
    logic [TIME_W:0]     trial;
    logic [TIME_W:0]     trial_sub;
    logic                qbit;
    logic                sat;
    logic [VALUE_W-1:0]  qmag;

    assign acc_sum   = acc_reg + (k_reg[0] ? mcand_reg : '0);
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dt_reg};
    assign qbit      = !trial_sub[TIME_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcnt_reg  <= mcnt_next;
        dcnt_reg  <= dcnt_next;
        k_reg     <= k_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        dvd_reg   <= dvd_next;
        dt_reg    <= dt_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
        neg_reg   <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        dcnt_next  = dcnt_reg;
        k_next     = k_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        dt_next    = dt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    k_next     = MUL_K;
                    mcand_next = PROD_W'(mag);
                    acc_next   = '0;
                    dt_next    = dt;
                    neg_next   = neg;
                    mcnt_next  = MCNT_W'(MUL_K_W - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                // shift-add, one constant bit per cycle
                acc_next   = acc_sum;
                mcand_next = mcand_reg << 1;
                k_next     = k_reg >> 1;
                mcnt_next  = mcnt_reg - MCNT_W'(1);
                if (mcnt_reg == '0)
                begin
                    dvd_next   = {acc_sum, {MUL_SH{1'b0}}};
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    dcnt_next  = DCNT_W'(DVD_W - 1);
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = qbit ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
                dvd_next  = dvd_reg << 1;
                q_next    = {q_reg[VALUE_W-1:0], qbit};
                ovf_next  = ovf_reg | q_reg[VALUE_W];
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (neg_reg)
        begin
            sat = ovf_reg | q_reg[VALUE_W] | (q_reg[VALUE_W-1] & (|q_reg[VALUE_W-2:0]));
            qmag = sat ? SLOPE_MIN : q_reg[VALUE_W-1:0];
            status.slope = '0 - qmag;
        end
        else
        begin
            sat = ovf_reg | q_reg[VALUE_W] | q_reg[VALUE_W-1];
            qmag = sat ? SLOPE_MAX : q_reg[VALUE_W-1:0];
            status.slope = qmag;
        end
        status.sat  = sat;
        status.done = (state_reg == M_DONE);
    end

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wse_pkg::*;

    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 117;
    localparam int SETTLE_CYCLES   = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] slope;
        logic               sat;
        logic [TIME_W-1:0]  stamp;
    } slope_result_t;

    class slope_scoreboard;
        logic signed [VALUE_W-1:0] value_ring [MAX_WINDOW];
        logic [TIME_W-1:0]         stamp_ring [MAX_WINDOW];
        int unsigned               held;
        int unsigned               slot;
        logic [WIN_W-1:0]          window;
        slope_result_t             awaited [$];
        int unsigned               errors;
        int unsigned               results;
        int unsigned               saturated;
        int unsigned               zeros;

        function new();
            held      = 0;
            slot      = 0;
            window    = WIN_W'(2);
            errors    = 0;
            results   = 0;
            saturated = 0;
            zeros     = 0;
        endfunction

        function int unsigned kept_limit();
            if (window == '0)
            begin
                return 1;
            end
            if (int'(window) > MAX_WINDOW)
            begin
                return MAX_WINDOW;
            end
            return int'(window);
        endfunction

        function void set_window(input logic [WIN_W-1:0] w);
            window = w;
            if (held > kept_limit())
            begin
                held = kept_limit();
            end
        endfunction

        function void note_sample(input logic signed [VALUE_W-1:0] value,
                                  input logic [TIME_W-1:0] stamp);
            int unsigned       newest;
            int unsigned       oldest;
            longint            diff;
            longint unsigned   mag;
            longint unsigned   dt;
            longint unsigned   quot;
            slope_result_t     r;
            newest             = slot;
            value_ring[newest] = value;
            stamp_ring[newest] = stamp;
            slot               = (slot + 1) % MAX_WINDOW;
            if (held < kept_limit())
            begin
                held++;
            end
            r.slope = '0;
            r.sat   = 1'b0;
            r.stamp = stamp;
            if (held >= 2)
            begin
                oldest = (newest + MAX_WINDOW - (held - 1)) % MAX_WINDOW;
                if (stamp_ring[newest] > stamp_ring[oldest])
                begin
                    dt   = stamp_ring[newest] - stamp_ring[oldest];
                    diff = longint'(value_ring[newest]) - longint'(value_ring[oldest]);
                    mag  = (diff < 0) ? longint'(-diff) : diff;
                    quot = (mag * 64'd1000000) / dt;
                    if (diff < 0)
                    begin
                        if (quot > 64'h8000_0000)
                        begin
                            r.slope = SLOPE_MIN;
                            r.sat   = 1'b1;
                        end
                        else
                        begin
                            r.slope = VALUE_W'(64'd0 - quot);
                        end
                    end
                    else
                    begin
                        if (quot > 64'h7fff_ffff)
                        begin
                            r.slope = SLOPE_MAX;
                            r.sat   = 1'b1;
                        end
                        else
                        begin
                            r.slope = VALUE_W'(quot);
                        end
                    end
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(input slope_result_t got);
            slope_result_t exp;
            if (awaited.size() == 0)
            begin
                $error("result with no request waiting: slope %0d", $signed(got.slope));
                errors++;
                return;
            end
            exp = awaited[0];
            awaited.delete(0);
            results++;
            if (exp.sat)
            begin
                saturated++;
            end
            if (exp.slope == '0)
            begin
                zeros++;
            end
            if (got.slope !== exp.slope)
            begin
                $error("slope expected %0d actual %0d", $signed(exp.slope), $signed(got.slope));
                errors++;
            end
            if (got.sat !== exp.sat)
            begin
                $error("slope_saturated expected %0b actual %0b", exp.sat, got.sat);
                errors++;
            end
            if (got.stamp !== exp.stamp)
            begin
                $error("result_time_us expected %0d actual %0d", exp.stamp, got.stamp);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wse_sample_if sample_ch ();
    wse_result_if result_ch ();
    wse_cfg_if    cfg_ch ();

    windowed_slope_estimator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    slope_scoreboard           sb;
    int                        send_quiet;
    int                        recv_quiet;
    logic signed [VALUE_W-1:0] walk_value;
    logic [TIME_W-1:0]         walk_stamp;
    int unsigned               settings_used;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(5, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic send_sample(input logic signed [VALUE_W-1:0] value,
                               input logic [TIME_W-1:0] stamp);
        int gap;
        gap = draw_gap(send_quiet);
        repeat (gap)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid          <= 1'b1;
        sample_ch.sample_value   <= value;
        sample_ch.sample_time_us <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        sb.note_sample(value, stamp);
    endtask

    // hold requests back until every result is out
    task automatic drain(input int extra);
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        sb.set_window(w);
        settings_used++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] next_value(
        input logic signed [VALUE_W-1:0] prev);
        int step;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                step = ($urandom_range(0, 2000) - 1000) <<< $urandom_range(0, 14);
                return prev + step;
            end
            6, 7:    return $urandom;
            8:       return $urandom_range(0, 1) ? SLOPE_MAX : SLOPE_MIN;
            default: return prev;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] prev);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                     return prev + $urandom_range(1, 5000);
            12, 13:  return prev + $urandom_range(5000, 2000000);
            14:      return prev + {32'd0, $urandom};
            15:      return prev;
            16:      return prev - $urandom_range(1, 1000);
            17:      return {$urandom, $urandom};
            default: return prev + 1;
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                drain(0);
            end
            walk_value = next_value(walk_value);
            walk_stamp = next_stamp(walk_stamp);
            send_sample(walk_value, walk_stamp);
        end
    endtask

    // result side
    initial
    begin
        slope_result_t got;
        int            gap;
        result_ch.ready = 1'b0;
        forever
        begin
            gap = draw_gap(recv_quiet);
            repeat (gap)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!result_ch.valid);
            got.slope = result_ch.slope;
            got.sat   = result_ch.slope_saturated;
            got.stamp = result_ch.result_time_us;
            sb.check_result(got);
        end
    end

    initial
    begin
        logic [WIN_W-1:0] settings [12];
        logic [WIN_W-1:0] w;
        sample_ch.valid          = 1'b0;
        sample_ch.sample_value   = '0;
        sample_ch.sample_time_us = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.window_size       = '0;
        rst_n                    = 1'b0;
        send_quiet               = 0;
        recv_quiet               = 0;
        settings_used            = 0;
        sb                       = new();
        settings = '{7'd0, 7'd1, 7'd64, 7'd3, 7'd127, 7'd2,
                     7'd65, 7'd17, 7'd64, 7'd4, 7'd100, 7'd9};
        repeat (12)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window of two
        send_sample(32'sd0, 64'd100);
        send_sample(SLOPE_MAX, 64'd100);
        send_sample(SLOPE_MIN, 64'd50);
        send_sample(SLOPE_MAX, 64'd51);
        send_sample(SLOPE_MIN, 64'd52);
        send_sample(32'sd0, 64'd1000);
        send_sample(SLOPE_MIN, 64'd1001000);
        send_sample(32'sd0, 64'd2001000);
        send_sample(SLOPE_MAX, 64'd3001000);
        send_sample(32'sd0, 64'd4001000);
        send_sample(-32'sd10, 64'd7001000);
        send_sample(32'sd0, 64'd7001001);
        send_sample(32'sd1, 64'hffff_ffff_ffff_ffff);
        send_sample(32'sd5, 64'd0);
        send_sample(-32'sd1, 64'd0);
        send_sample(32'sh5555_aaaa, 64'haaaa_5555_aaaa_5555);
        send_sample(32'shaaaa_5555, 64'haaaa_5555_aaaa_5556);
        walk_value = 32'sh0001_0000;
        walk_stamp = 64'd1_000_000;

        for (int p = 0; p < PHASES; p++)
        begin
            drain(80);
            w = (p < 12) ? settings[p] : WIN_W'($urandom_range(0, 127));
            write_window(w);
            run_random(ITEMS_PER_PHASE);
        end

        drain(SETTLE_CYCLES);
        $display("checked %0d results across %0d window settings", sb.results, settings_used);
        $display("%0d results saturated, %0d results zero", sb.saturated, sb.zeros);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/wse_pkg.sv
rtl/wse_ifs.sv
rtl/wse_ram.sv
rtl/wse_muldiv.sv
rtl/windowed_slope_estimator_top.sv
sim/testbench.sv
